// ===== hdl/gyro_stationary_bias_calibration_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef GYRO_STATIONARY_BIAS_CALIBRATION_UNIT_MACROS_SVH
`define GYRO_STATIONARY_BIAS_CALIBRATION_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define GSBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsbc check failed in %m");

// Next-cycle implication, sampled on clk and disabled during rst.
`define GSBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsbc check failed in %m");

`endif

// ===== hdl/gsbc_pkg.sv =====
package gsbc_pkg;

  localparam int SUM_BITS     = 32;
  localparam int CFG_BITS     = 16;
  localparam int TALLY_BITS   = 16;
  localparam int AXES         = 3;
  localparam int AXIS_BITS    = 2;
  localparam int CFG_IDX_BITS = 1;

  typedef logic [AXIS_BITS-1:0] axis_t;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 1'b1;

  localparam logic [CFG_BITS-1:0] RANGE_LIMIT_RST   = 16'd20;
  localparam logic [CFG_BITS-1:0] WINDOW_LENGTH_RST = 16'd1000;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ACC    = 6'b000010,
    S_DECIDE = 6'b000100,
    S_LOAD   = 6'b001000,
    S_DIV    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic  upd;
    logic  clear;
    axis_t axis;
  } acc_ctl_t;

endpackage

// ===== hdl/gsbc_ifs.sv =====
interface gsbc_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] rate_x;
  logic signed [SAMPLE_BITS-1:0] rate_y;
  logic signed [SAMPLE_BITS-1:0] rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

interface gsbc_result_if #(
  parameter int BIAS_BITS = 20
);
  logic                        valid;
  logic                        ready;
  logic                        done_res;
  logic                        unstable;
  logic signed [BIAS_BITS-1:0] bias_x;
  logic signed [BIAS_BITS-1:0] bias_y;
  logic signed [BIAS_BITS-1:0] bias_z;

  modport source (output valid, output done_res, output unstable, output bias_x,
                  output bias_y, output bias_z, input ready);
  modport sink (input valid, input done_res, input unstable, input bias_x,
                input bias_y, input bias_z, output ready);
endinterface

interface gsbc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [gsbc_pkg::CFG_IDX_BITS-1:0] index;
  logic [gsbc_pkg::CFG_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/gsbc_axis.sv =====
module gsbc_axis #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  gsbc_pkg::acc_ctl_t              ctl,
  input  logic signed [SAMPLE_BITS-1:0]   sample,
  input  logic [gsbc_pkg::CFG_BITS-1:0]   range_limit,
  output logic [gsbc_pkg::SUM_BITS-1:0]   sum_rd,
  output logic                            wide
);

  localparam int CW = (SAMPLE_BITS > gsbc_pkg::CFG_BITS) ? SAMPLE_BITS : gsbc_pkg::CFG_BITS;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic signed [SAMPLE_BITS-1:0]  mx [gsbc_pkg::AXES];
  logic signed [SAMPLE_BITS-1:0]  mn [gsbc_pkg::AXES];
  logic [gsbc_pkg::SUM_BITS-1:0]  acc [gsbc_pkg::AXES];

  logic signed [SAMPLE_BITS-1:0]  cur_mx;
  logic signed [SAMPLE_BITS-1:0]  cur_mn;
  logic signed [SAMPLE_BITS-1:0]  new_mx;
  logic signed [SAMPLE_BITS-1:0]  new_mn;
  logic [gsbc_pkg::SUM_BITS-1:0]  cur_sum;
  logic [gsbc_pkg::SUM_BITS-1:0]  new_sum;
  logic [SAMPLE_BITS-1:0]         spread;

  always_comb begin
    cur_mx  = ctl.clear ? S_MIN : mx[ctl.axis];
    cur_mn  = ctl.clear ? S_MAX : mn[ctl.axis];
    cur_sum = ctl.clear ? '0 : acc[ctl.axis];
    new_mx  = (sample > cur_mx) ? sample : cur_mx;
    new_mn  = (sample < cur_mn) ? sample : cur_mn;
    new_sum = cur_sum + {{(gsbc_pkg::SUM_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
    spread  = SAMPLE_BITS'(new_mx - new_mn);
    wide    = CW'(spread) > CW'(range_limit);
  end

  assign sum_rd = acc[ctl.axis];

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      mx[ctl.axis]  <= new_mx;
      mn[ctl.axis]  <= new_mn;
      acc[ctl.axis] <= new_sum;
    end
  end

endmodule

// ===== hdl/gsbc_div.sv =====
module gsbc_div #(
  parameter int FRAC_BITS = 4,
  parameter int BIAS_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [gsbc_pkg::SUM_BITS-1:0]     dividend,
  input  logic [gsbc_pkg::TALLY_BITS-1:0]   divisor,
  output logic                              done,
  output logic signed [BIAS_BITS-1:0]       quotient
);

  localparam int DIV_W = gsbc_pkg::SUM_BITS + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int TB    = gsbc_pkg::TALLY_BITS;
  localparam logic [DIV_W-1:0] LIM = DIV_W'(1) << (BIAS_BITS - 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic                          neg;
  logic [TB-1:0]                 rem;
  logic [DIV_W-1:0]              quo;
  logic [gsbc_pkg::SUM_BITS-1:0] mag;
  logic [TB:0]                   trial;
  logic [TB:0]                   diff;
  logic                          fits;

  always_comb begin
    mag   = dividend[gsbc_pkg::SUM_BITS-1] ? (gsbc_pkg::SUM_BITS'(0) - dividend) : dividend;
    trial = {rem, quo[DIV_W-1]};
    fits  = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[gsbc_pkg::SUM_BITS-1];
      rem <= '0;
      quo <= DIV_W'(mag) << FRAC_BITS;
    end else if (busy) begin
      rem <= fits ? diff[TB-1:0] : trial[TB-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  // Results beyond the signed field saturate.
  always_comb begin
    if (neg) begin
      if (quo > LIM) begin
        quotient = $signed({1'b1, {(BIAS_BITS-1){1'b0}}});
      end else begin
        quotient = $signed(BIAS_BITS'(0) - quo[BIAS_BITS-1:0]);
      end
    end else begin
      if (quo >= LIM) begin
        quotient = $signed({1'b0, {(BIAS_BITS-1){1'b1}}});
      end else begin
        quotient = $signed(quo[BIAS_BITS-1:0]);
      end
    end
  end

endmodule

// ===== hdl/gyro_stationary_bias_calibration_unit.sv =====
// Channel   Role    Word
// samples   sink    rate_x, rate_y, rate_z
// results   source  done_res, unstable, bias_x, bias_y, bias_z
// cfg       sink    index, data (0: range_limit, 1: window_length)
//
// A sample that does not close a window passes S_ACC, S_DECIDE and S_EMIT before the next
// ready. A sample that closes a window also passes S_LOAD and S_DIV once per axis, since one
// serial divider produces one quotient bit per cycle and serves the three axes in turn.
// The three axis updates share one accumulate and compare unit, one axis per cycle.
// Reset is synchronous; the first sample after reset opens a new window.
// A new sample is taken while the previous result still waits in the output register.
module gyro_stationary_bias_calibration_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 4
) (
  input logic           clk,
  input logic           rst,
  gsbc_sample_if.sink   samples,
  gsbc_result_if.source results,
  gsbc_cfg_if.sink      cfg
);

  localparam int BIAS_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int TB        = gsbc_pkg::TALLY_BITS;

  gsbc_pkg::state_t              state;
  gsbc_pkg::state_t              state_next;
  gsbc_pkg::axis_t               ax;
  gsbc_pkg::acc_ctl_t            ctl;

  logic [gsbc_pkg::CFG_BITS-1:0] range_limit;
  logic [gsbc_pkg::CFG_BITS-1:0] window_length;
  logic [TB-1:0]                 tally;
  logic [TB-1:0]                 tally_inc;
  logic [TB-1:0]                 limit_len;
  logic                          win_full;
  logic                          wide;
  logic                          clear_win;
  logic                          win_done;

  logic signed [SAMPLE_BITS-1:0] sx;
  logic signed [SAMPLE_BITS-1:0] sy;
  logic signed [SAMPLE_BITS-1:0] sz;
  logic signed [SAMPLE_BITS-1:0] sample_sel;
  logic signed [BIAS_BITS-1:0]   bias [gsbc_pkg::AXES];

  logic [gsbc_pkg::SUM_BITS-1:0] sum_rd;
  logic                          acc_wide;
  logic                          div_done;
  logic signed [BIAS_BITS-1:0]   div_q;

  logic                          out_valid;
  logic                          out_done;
  logic                          out_unstable;
  logic signed [BIAS_BITS-1:0]   out_bx;
  logic signed [BIAS_BITS-1:0]   out_by;
  logic signed [BIAS_BITS-1:0]   out_bz;

  assign samples.ready    = (state == gsbc_pkg::S_IDLE);
  assign cfg.ready        = 1'b1;
  assign results.valid    = out_valid;
  assign results.done_res = out_done;
  assign results.unstable = out_unstable;
  assign results.bias_x   = out_bx;
  assign results.bias_y   = out_by;
  assign results.bias_z   = out_bz;

  always_comb begin
    case (ax)
      gsbc_pkg::AXIS_X: sample_sel = sx;
      gsbc_pkg::AXIS_Y: sample_sel = sy;
      default:          sample_sel = sz;
    endcase
    ctl.upd   = (state == gsbc_pkg::S_ACC);
    ctl.clear = clear_win;
    ctl.axis  = ax;
    tally_inc = tally + 1'b1;
    limit_len = (window_length == '0) ? TB'(1) : TB'(window_length);
    win_full  = tally_inc >= limit_len;
  end

  gsbc_axis #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_axis (
    .clk        (clk),
    .ctl        (ctl),
    .sample     (sample_sel),
    .range_limit(range_limit),
    .sum_rd     (sum_rd),
    .wide       (acc_wide)
  );

  gsbc_div #(
    .FRAC_BITS(FRAC_BITS),
    .BIAS_BITS(BIAS_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (state == gsbc_pkg::S_LOAD),
    .dividend(sum_rd),
    .divisor (tally),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      gsbc_pkg::S_IDLE: begin
        if (samples.valid) state_next = gsbc_pkg::S_ACC;
      end
      gsbc_pkg::S_ACC: begin
        if (ax == gsbc_pkg::AXIS_Z) state_next = gsbc_pkg::S_DECIDE;
      end
      gsbc_pkg::S_DECIDE: begin
        state_next = (!wide && win_full) ? gsbc_pkg::S_LOAD : gsbc_pkg::S_EMIT;
      end
      gsbc_pkg::S_LOAD: begin
        state_next = gsbc_pkg::S_DIV;
      end
      gsbc_pkg::S_DIV: begin
        if (div_done) begin
          state_next = (ax == gsbc_pkg::AXIS_Z) ? gsbc_pkg::S_EMIT : gsbc_pkg::S_LOAD;
        end
      end
      gsbc_pkg::S_EMIT: begin
        if (!out_valid || results.ready) state_next = gsbc_pkg::S_IDLE;
      end
      default: begin
        state_next = gsbc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gsbc_pkg::S_IDLE;
      ax            <= gsbc_pkg::AXIS_X;
      tally         <= '0;
      wide          <= 1'b0;
      clear_win     <= 1'b0;
      win_done      <= 1'b0;
      out_valid     <= 1'b0;
      range_limit   <= gsbc_pkg::RANGE_LIMIT_RST;
      window_length <= gsbc_pkg::WINDOW_LENGTH_RST;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          gsbc_pkg::REG_RANGE_LIMIT:   range_limit   <= cfg.data;
          gsbc_pkg::REG_WINDOW_LENGTH: window_length <= cfg.data;
          default: ;
        endcase
      end
      if (state == gsbc_pkg::S_EMIT && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        gsbc_pkg::S_IDLE: begin
          if (samples.valid) begin
            ax        <= gsbc_pkg::AXIS_X;
            wide      <= 1'b0;
            clear_win <= (tally == '0);
            win_done  <= 1'b0;
          end
        end
        gsbc_pkg::S_ACC: begin
          wide <= wide | acc_wide;
          ax   <= (ax == gsbc_pkg::AXIS_Z) ? gsbc_pkg::AXIS_X : gsbc_pkg::axis_t'(ax + 1'b1);
        end
        gsbc_pkg::S_DECIDE: begin
          tally    <= wide ? '0 : tally_inc;
          win_done <= !wide && win_full;
        end
        gsbc_pkg::S_DIV: begin
          if (div_done) begin
            ax <= (ax == gsbc_pkg::AXIS_Z) ? gsbc_pkg::AXIS_X : gsbc_pkg::axis_t'(ax + 1'b1);
            if (ax == gsbc_pkg::AXIS_Z) tally <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      sx <= samples.rate_x;
      sy <= samples.rate_y;
      sz <= samples.rate_z;
    end
    if (state == gsbc_pkg::S_DIV && div_done) begin
      bias[ax] <= div_q;
    end
    if (state == gsbc_pkg::S_EMIT && (!out_valid || results.ready)) begin
      out_done     <= win_done;
      out_unstable <= wide;
      out_bx       <= win_done ? bias[gsbc_pkg::AXIS_X] : '0;
      out_by       <= win_done ? bias[gsbc_pkg::AXIS_Y] : '0;
      out_bz       <= win_done ? bias[gsbc_pkg::AXIS_Z] : '0;
    end
  end

endmodule

// ===== hdl/gsbc_checker.sv =====
`include "gyro_stationary_bias_calibration_unit_macros.svh"

module gsbc_checker #(
  parameter int BIAS_BITS = 20
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        done_res,
  input logic                        unstable,
  input logic signed [BIAS_BITS-1:0] bias_x,
  input logic signed [BIAS_BITS-1:0] bias_y,
  input logic signed [BIAS_BITS-1:0] bias_z
);

  // An unstable sample never closes a window.
  `GSBC_ASSERT_IMP(a_done_not_unstable, out_valid, !(done_res && unstable))

  // Offsets are only reported with a closed window.
  `GSBC_ASSERT_IMP(a_bias_zero_open, out_valid && !done_res, bias_x == '0 && bias_y == '0 && bias_z == '0)

  // The block works on one sample at a time.
  `GSBC_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)

  `GSBC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(done_res) && $stable(bias_x))

endmodule

bind gyro_stationary_bias_calibration_unit gsbc_checker #(
  .BIAS_BITS(SAMPLE_BITS + FRAC_BITS)
) u_gsbc_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (samples.valid),
  .in_ready (samples.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .done_res (results.done_res),
  .unstable (results.unstable),
  .bias_x   (results.bias_x),
  .bias_y   (results.bias_y),
  .bias_z   (results.bias_z)
);

// ===== test/bias_calib_checker.sv =====
`timescale 1ns / 1ps

module bias_calib_checker (
  input  logic   clk,
  input  logic   rst,
  gsbc_sample_if samples,
  gsbc_result_if results,
  gsbc_cfg_if    cfg,
  output int     fail_count,
  output int     pending_words
);

  localparam int     SAMPLE_W = 16;
  localparam int     FRAC_W   = 4;
  localparam int     BIAS_W   = SAMPLE_W + FRAC_W;
  localparam longint BIAS_TOP = (longint'(1) <<< (BIAS_W - 1)) - 1;

  typedef struct packed {
    logic                     done_res;
    logic                     unstable;
    logic signed [BIAS_W-1:0] bias_x;
    logic signed [BIAS_W-1:0] bias_y;
    logic signed [BIAS_W-1:0] bias_z;
  } calib_word_t;

  logic [gsbc_pkg::CFG_BITS-1:0]   spread_limit;
  logic [gsbc_pkg::CFG_BITS-1:0]   window_len;
  logic signed [31:0]              axis_acc [3];
  logic signed [SAMPLE_W-1:0]      axis_hi [3];
  logic signed [SAMPLE_W-1:0]      axis_lo [3];
  logic [gsbc_pkg::TALLY_BITS-1:0] still_count;
  calib_word_t                     expected_words [$];

  // Mean in fixed point, truncated toward zero and clamped to the bias range.
  function automatic logic signed [BIAS_W-1:0] fixed_mean(input logic signed [31:0] total,
                                                          input logic [15:0] count);
    longint mag;
    longint quot;
    logic   neg;
    neg  = total[31];
    mag  = neg ? -longint'(total) : longint'(total);
    quot = (mag <<< FRAC_W) / longint'(count);
    if (neg) begin
      if (quot > BIAS_TOP + 1) return BIAS_W'(-BIAS_TOP - 1);
      return BIAS_W'(-quot);
    end
    if (quot > BIAS_TOP) return BIAS_W'(BIAS_TOP);
    return BIAS_W'(quot);
  endfunction

  function automatic calib_word_t track_sample(input logic signed [SAMPLE_W-1:0] rx, ry, rz);
    logic signed [SAMPLE_W-1:0] s [3];
    calib_word_t                w;
    logic                       wide;
    logic [16:0]                need;
    s[0] = rx;
    s[1] = ry;
    s[2] = rz;
    if (still_count == '0) begin
      for (int i = 0; i < 3; i++) begin
        axis_acc[i] = '0;
        axis_hi[i]  = 16'sh8000;
        axis_lo[i]  = 16'sh7fff;
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (s[i] > axis_hi[i]) axis_hi[i] = s[i];
      if (s[i] < axis_lo[i]) axis_lo[i] = s[i];
      axis_acc[i] = axis_acc[i] + s[i];
    end
    still_count = still_count + 16'd1;
    wide = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (int'(axis_hi[i]) - int'(axis_lo[i]) > int'(spread_limit)) wide = 1'b1;
    end
    if (wide) still_count = '0;
    w = '0;
    w.unstable = wide;
    need = (window_len == '0) ? 17'd1 : {1'b0, window_len};
    if ({1'b0, still_count} >= need) begin
      w.done_res = 1'b1;
      w.bias_x   = fixed_mean(axis_acc[0], still_count);
      w.bias_y   = fixed_mean(axis_acc[1], still_count);
      w.bias_z   = fixed_mean(axis_acc[2], still_count);
      still_count = '0;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    calib_word_t got;
    calib_word_t want;
    if (rst) begin
      spread_limit = gsbc_pkg::RANGE_LIMIT_RST;
      window_len   = gsbc_pkg::WINDOW_LENGTH_RST;
      still_count  = '0;
      for (int i = 0; i < 3; i++) begin
        axis_acc[i] = '0;
        axis_hi[i]  = 16'sh8000;
        axis_lo[i]  = 16'sh7fff;
      end
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (results.valid && results.ready) begin
        got = '{results.done_res, results.unstable, results.bias_x, results.bias_y,
                results.bias_z};
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: result word with none expected: done=%0b unstable=%0b bias=%0d/%0d/%0d",
                   $time, got.done_res, got.unstable, $signed(got.bias_x),
                   $signed(got.bias_y), $signed(got.bias_z));
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: result word mismatch: expected done=%0b unstable=%0b bias=%0d/%0d/%0d, got done=%0b unstable=%0b bias=%0d/%0d/%0d",
                     $time, want.done_res, want.unstable, $signed(want.bias_x),
                     $signed(want.bias_y), $signed(want.bias_z), got.done_res,
                     got.unstable, $signed(got.bias_x), $signed(got.bias_y),
                     $signed(got.bias_z));
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          gsbc_pkg::REG_RANGE_LIMIT: spread_limit = cfg.data;
          gsbc_pkg::REG_WINDOW_LENGTH: window_len = cfg.data;
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        expected_words.push_back(track_sample(samples.rate_x, samples.rate_y, samples.rate_z));
      end
    end
    pending_words = expected_words.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS = 1750;

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   sent_count = 0;
  int   results_seen = 0;
  int   fail_count;
  int   pending_words;

  gsbc_sample_if #(.SAMPLE_BITS(16)) sample_ch ();
  gsbc_result_if #(.BIAS_BITS(20))   result_ch ();
  gsbc_cfg_if                        cfg_ch ();

  gyro_stationary_bias_calibration_unit #(
    .SAMPLE_BITS(16),
    .FRAC_BITS  (4)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .samples(sample_ch),
    .results(result_ch),
    .cfg    (cfg_ch)
  );

  bias_calib_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .samples      (sample_ch),
    .results      (result_ch),
    .cfg          (cfg_ch),
    .fail_count   (fail_count),
    .pending_words(pending_words)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && result_ch.valid && result_ch.ready) results_seen <= results_seen + 1;
  end

  task automatic send_sample(input logic signed [15:0] x, y, z);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.rate_x <= x;
    sample_ch.rate_y <= y;
    sample_ch.rate_z <= z;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic set_config(input logic [15:0] limit, length);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= gsbc_pkg::REG_RANGE_LIMIT;
    cfg_ch.data  <= limit;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= gsbc_pkg::REG_WINDOW_LENGTH;
    cfg_ch.data  <= length;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    sample_ch.valid <= 1'b0;
    while (results_seen != sent_count) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [15:0] any_rate();
    return 16'($urandom);
  endfunction

  initial begin
    #(40_000_000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int sent_base;
    int phase;
    int limit;
    int length;
    int span;
    int win_n;
    int roll;
    int base [3];
    int pick [3];

    rst              <= 1'b1;
    sample_ch.valid  <= 1'b0;
    sample_ch.rate_x <= '0;
    sample_ch.rate_y <= '0;
    sample_ch.rate_z <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= gsbc_pkg::REG_RANGE_LIMIT;
    cfg_ch.data      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a wide jump restarts the window and flags it.
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd32767, -16'sd32768, 16'sd0);
    send_sample(-16'sd32768, 16'sd32767, -16'sd1);
    wait_for_results();

    // A window length of zero closes a window on every word.
    set_config(16'd0, 16'd0);
    send_sample(16'sd5, -16'sd7, 16'sd100);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(16'sd1, 16'sd1, 16'sd1);
    wait_for_results();

    // Full spread is still allowed at the widest limit.
    set_config(16'd65535, 16'd65535);
    send_sample(16'sd32767, -16'sd32768, 16'sd12345);
    send_sample(-16'sd32768, 16'sd32767, -16'sd1);
    repeat (6) send_sample(any_rate(), any_rate(), any_rate());
    wait_for_results();

    // Shortening the window mid-way closes it on the next word.
    set_config(16'd65535, 16'd3);
    send_sample(-16'sd21845, 16'sd10922, 16'sd32767);
    wait_for_results();

    // Negative sums truncate toward zero; a spread one past the limit restarts.
    set_config(16'd3, 16'd3);
    send_sample(-16'sd1, 16'sd0, 16'sd1);
    send_sample(-16'sd1, 16'sd0, 16'sd0);
    send_sample(16'sd0, -16'sd1, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd4, 16'sd0, 16'sd0);
    send_sample(16'sd3, 16'sd3, 16'sd3);
    wait_for_results();

    sent_base = sent_count;
    phase = 0;
    while (sent_count < sent_base + RANDOM_ITEMS) begin
      case (phase % 5)
        1: begin
          send_idle_pct = 54;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 54;
        end
        3: begin
          send_idle_pct = 7;
          stall_pct     = 7;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      case ($urandom_range(9))
        0: limit = 0;
        1: limit = 65535;
        2: limit = $urandom_range(65535);
        default: limit = $urandom_range(64, 1);
      endcase
      roll = $urandom_range(19);
      if (roll == 0) length = 0;
      else if (roll == 1) length = 65535;
      else if (roll < 4) length = $urandom_range(40, 13);
      else length = $urandom_range(12, 1);
      set_config(16'(limit), 16'(length));
      span = limit;
      for (int n = $urandom_range(120, 40); n > 0; n -= win_n) begin
        if (length == 0) win_n = 1;
        else if (length > 40) win_n = $urandom_range(30, 10);
        else win_n = length;
        for (int a = 0; a < 3; a++) base[a] = int'($urandom_range(65535 - span)) - 32768;
        for (int k = 0; k < win_n; k++) begin
          roll = $urandom_range(99);
          if (roll < 4 && base[0] + span < 32767) begin
            send_sample(16'(base[0] + span + 1), 16'(base[1]), 16'(base[2]));
          end else if (roll < 9) begin
            send_sample(any_rate(), any_rate(), any_rate());
          end else begin
            for (int a = 0; a < 3; a++) pick[a] = base[a] + int'($urandom_range(span));
            send_sample(16'(pick[0]), 16'(pick[1]), 16'(pick[2]));
          end
        end
      end
      wait_for_results();
      phase++;
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/gsbc_pkg.sv
hdl/gsbc_ifs.sv
hdl/gsbc_axis.sv
hdl/gsbc_div.sv
hdl/gyro_stationary_bias_calibration_unit.sv
hdl/gsbc_checker.sv
test/bias_calib_checker.sv
test/tb.sv
